// ----- hw/rtl/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner.
// Holds widths, configuration register indexes and the wildcard code.
// No dependencies; the channel interfaces and the top level use it.
package wbps_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int ADDR_BITS     = 48;
  localparam int PAT_IDX_BITS  = $clog2(PATTERN_MAX);
  localparam int LEN_BITS      = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;

  typedef logic [7:0]             byte_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [PAT_IDX_BITS-1:0] pat_idx_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_PATTERN_LOW    = 2'd0;
  localparam cfg_idx_t CFG_PATTERN_HIGH   = 2'd1;
  localparam cfg_idx_t CFG_PATTERN_LENGTH = 2'd2;

  // Pattern byte that matches any data byte ('?')
  localparam byte_t WILDCARD_BYTE = 8'h3F;

  localparam len_t LEN_MIN   = len_t'(1);
  localparam len_t LEN_LIMIT = len_t'(PATTERN_MAX);

endpackage

// ----- hw/rtl/wbps_if.sv -----
// Valid/ready channel interfaces for the scanner: byte input and result output.
// Depends on wbps_pkg for field types.
interface wbps_in_if;
  logic             valid;
  logic             ready;
  wbps_pkg::byte_t  data_byte;
  wbps_pkg::addr_t  byte_address;
  logic             page_first;
  logic             scan_first;
  logic             scan_last;

  modport source (output valid, data_byte, byte_address, page_first, scan_first, scan_last,
                  input ready);
  modport sink   (input valid, data_byte, byte_address, page_first, scan_first, scan_last,
                  output ready);
endinterface

interface wbps_out_if;
  logic             valid;
  logic             ready;
  logic             found;
  wbps_pkg::addr_t  match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

// ----- hw/rtl/wildcard_byte_pattern_scan_top.sv -----
// Top level of the wildcard byte pattern scanner: window, compare and result register.
// Depends on wbps_pkg and the channel interfaces in wbps_if.sv.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  in_if    | in  | valid / ready      | data_byte, byte_address, page/scan_first, scan_last
//  out_if   | out | valid / ready      | found, match_address
//  cfg_*    | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
// One byte per cycle unless stalled: each transfer shifts the window, compares it with
// the pattern and loads any result into the output register at the same edge.
// The sustained rate is set by the single output register: the input stalls only while
// a result waits there and out_if.ready is low.
// Reset (synchronous, rst_n low) clears the pattern to zero, length to one, and leaves
// the block idle until a byte with scan_first arrives. No clearing pass is needed.
module wildcard_byte_pattern_scan_top (
  input  logic                    clk,
  input  logic                    rst_n,
  wbps_in_if.sink                 in_if,
  wbps_out_if.source              out_if,
  input  logic                    cfg_we,
  input  wbps_pkg::cfg_idx_t      cfg_index,
  input  wbps_pkg::cfg_data_t     cfg_data
);

  // Configuration registers
  wbps_pkg::cfg_data_t pat_low_r;
  wbps_pkg::cfg_data_t pat_high_r;
  wbps_pkg::len_t      pat_len_r;

  // Scan state
  wbps_pkg::byte_t     win_r   [wbps_pkg::PATTERN_MAX];
  wbps_pkg::byte_t     win_nxt [wbps_pkg::PATTERN_MAX];
  wbps_pkg::len_t      fill_r, fill_nxt, fill_cur;
  logic                done_r, done_nxt, done_cur;

  // Result register
  logic                out_valid_r;
  logic                out_found_r, out_found_nxt;
  wbps_pkg::addr_t     out_addr_r, out_addr_nxt;
  logic                out_load;

  logic                in_xfer;
  wbps_pkg::len_t      len_used;
  wbps_pkg::pat_idx_t  len_m1;
  logic [2*wbps_pkg::CFG_DATA_BITS-1:0] pat_all;
  logic [wbps_pkg::PATTERN_MAX-1:0]     pos_ok;
  logic                hit;

  // Input stalls only when a result is held and not taken this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_xfer     = in_if.valid && in_if.ready;

  assign out_if.valid         = out_valid_r;
  assign out_if.found         = out_found_r;
  assign out_if.match_address = out_addr_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= wbps_pkg::LEN_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::CFG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        wbps_pkg::CFG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        wbps_pkg::CFG_PATTERN_LENGTH: pat_len_r  <= cfg_data[wbps_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length into 1..PATTERN_MAX
  always_comb begin
    if (pat_len_r == '0) begin
      len_used = wbps_pkg::LEN_MIN;
    end else if (pat_len_r > wbps_pkg::LEN_LIMIT) begin
      len_used = wbps_pkg::LEN_LIMIT;
    end else begin
      len_used = pat_len_r;
    end
    len_m1 = wbps_pkg::pat_idx_t'(len_used - wbps_pkg::LEN_MIN);
  end

  assign pat_all = {pat_high_r, pat_low_r};

  // Shift the new byte in at entry 0; restart the fill count on a page or scan start
  always_comb begin
    win_nxt[0] = in_if.data_byte;
    for (int k = 1; k < wbps_pkg::PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    fill_cur = (in_if.page_first || in_if.scan_first) ? '0 : fill_r;
    fill_nxt = (fill_cur < wbps_pkg::LEN_LIMIT) ? fill_cur + wbps_pkg::LEN_MIN : fill_cur;
  end

  // Pattern byte i lines up with window entry len-1-i; bytes past the length pass
  always_comb begin
    for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++) begin
      if (wbps_pkg::pat_idx_t'(i) > len_m1) begin
        pos_ok[i] = 1'b1;
      end else begin
        pos_ok[i] = (pat_all[8*i +: 8] == wbps_pkg::WILDCARD_BYTE) ||
                    (pat_all[8*i +: 8] ==
                     win_nxt[len_m1 - wbps_pkg::pat_idx_t'(i)]);
      end
    end
    hit = (fill_nxt >= len_used) && (&pos_ok);
  end

  // Decide on a result: first match wins, otherwise report not found at scan end
  always_comb begin
    done_cur      = in_if.scan_first ? 1'b0 : done_r;
    done_nxt      = done_cur;
    out_load      = 1'b0;
    out_found_nxt = 1'b0;
    out_addr_nxt  = '0;
    if (!done_cur) begin
      priority if (hit) begin
        out_load      = 1'b1;
        out_found_nxt = 1'b1;
        out_addr_nxt  = in_if.byte_address -
                        wbps_pkg::addr_t'(len_m1);
        done_nxt      = 1'b1;
      end else if (in_if.scan_last) begin
        out_load = 1'b1;
        done_nxt = 1'b1;
      end else begin
        // Keep the scan open, no result for this byte
        out_load = 1'b0;
      end
    end
  end

  // Window payload: no reset, entries beyond the fill count are never compared
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = 0; k < wbps_pkg::PATTERN_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      done_r <= 1'b1;
    end else if (in_xfer) begin
      fill_r <= fill_nxt;
      done_r <= done_nxt;
    end
  end

  // Output register: load on a result, drop when the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && out_load) begin
      out_found_r <= out_found_nxt;
      out_addr_r  <= out_addr_nxt;
    end
  end

  // A not-found result always carries a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_addr_r == '0)
    else $error("not-found result with nonzero address");

  // Any result closes the scan
  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && out_load |=> done_r)
    else $error("scan still open after a result");

  // No result while the scan is closed and no new scan starts
  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && done_r && !in_if.scan_first |-> !out_load)
    else $error("result given on a closed scan");

  // Fill count saturates at the pattern limit
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= wbps_pkg::LEN_LIMIT)
    else $error("fill count beyond limit");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the wildcard byte pattern scanner.
// Drives byte transfers through the RTL channel interfaces, predicts each report
// with a local scan model and checks it; depends on wbps_pkg and wbps_if.sv.
`timescale 1ns / 1ps

module tb_top;

  // Register index the block does not decode; writes to it must change nothing
  localparam wbps_pkg::cfg_idx_t CFG_SPARE = 2'd3;
  // Hard stop for a hung run, in clock cycles
  localparam int CYCLE_LIMIT = 100000;
  // Settle cycles waited after the last report, as margin for the output register
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic            found;
    wbps_pkg::addr_t match_address;
  } scan_report_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  wbps_pkg::cfg_idx_t  cfg_index;
  wbps_pkg::cfg_data_t cfg_data;

  wbps_in_if  in_if ();
  wbps_out_if out_if ();

  wildcard_byte_pattern_scan_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Reports the scan model says must come out, oldest first
  scan_report_t expected_reports[$];
  int error_count;
  int cycle_count;

  // Idle ranges for each side, redrawn per phase; zero gives back-to-back traffic
  int send_gap_max;
  int recv_gap_max;
  // Long receiver hold-off requested by the pressure test, consumed by the receiver
  int hold_off_len;

  // Scan model state: register copies, byte window and scan progress
  logic [63:0]     pat_lo;
  logic [63:0]     pat_hi;
  logic [4:0]      pat_len;
  wbps_pkg::byte_t scan_window [wbps_pkg::PATTERN_MAX];
  int              page_fill;
  bit              scan_idle;

  //--------------------------------------------------------------------------
  // Clock and watchdog
  //--------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and abort when the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Scan model
  //--------------------------------------------------------------------------
  function automatic int used_len();
    int n;
    n = int'(pat_len);
    if (n < 1) n = 1;
    if (n > wbps_pkg::PATTERN_MAX) n = wbps_pkg::PATTERN_MAX;
    return n;
  endfunction

  function automatic wbps_pkg::byte_t pattern_at(int i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic void apply_cfg(wbps_pkg::cfg_idx_t idx, wbps_pkg::cfg_data_t value);
    case (idx)
      wbps_pkg::CFG_PATTERN_LOW:    pat_lo = value;
      wbps_pkg::CFG_PATTERN_HIGH:   pat_hi = value;
      wbps_pkg::CFG_PATTERN_LENGTH: pat_len = value[4:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_scan_model();
    pat_lo = '0;
    pat_hi = '0;
    pat_len = 5'd1;
    foreach (scan_window[i]) scan_window[i] = '0;
    page_fill = 0;
    scan_idle = 1'b1;
  endfunction

  // Advance the model by one accepted byte and queue the report it causes, if any
  function automatic void predict_report(wbps_pkg::byte_t d, wbps_pkg::addr_t a,
                                         logic pf, logic sf, logic sl);
    int n;
    bit hit;
    wbps_pkg::byte_t p;
    scan_report_t rep;
    n = used_len();
    if (sf) scan_idle = 1'b0;
    if (pf || sf) page_fill = 0;
    for (int i = wbps_pkg::PATTERN_MAX - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = d;
    if (page_fill < wbps_pkg::PATTERN_MAX) page_fill++;
    if (scan_idle) return;
    if (page_fill >= n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        p = pattern_at(i);
        if (p != wbps_pkg::WILDCARD_BYTE && p != scan_window[n-1-i]) hit = 1'b0;
      end
      if (hit) begin
        rep.found = 1'b1;
        rep.match_address = a - wbps_pkg::addr_t'(n - 1);
        expected_reports.push_back(rep);
        scan_idle = 1'b1;
        return;
      end
    end
    if (sl) begin
      rep.found = 1'b0;
      rep.match_address = '0;
      expected_reports.push_back(rep);
      scan_idle = 1'b1;
    end
  endfunction

  //--------------------------------------------------------------------------
  // Driving and checking
  //--------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Offer one byte after a random gap, hold it until the transfer, then predict
  task automatic send_byte(wbps_pkg::byte_t d, wbps_pkg::addr_t a,
                           logic pf, logic sf, logic sl);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= d;
    in_if.byte_address <= a;
    in_if.page_first   <= pf;
    in_if.scan_first   <= sf;
    in_if.scan_last    <= sl;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    predict_report(d, a, pf, sf, sl);
  endtask

  // Drop valid and wait until every report is in and the pipeline is empty
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three pattern registers on consecutive edges
  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi,
                              wbps_pkg::cfg_data_t len_word);
    cfg_we    <= 1'b1;
    cfg_index <= wbps_pkg::CFG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    apply_cfg(wbps_pkg::CFG_PATTERN_LOW, lo);
    cfg_index <= wbps_pkg::CFG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    apply_cfg(wbps_pkg::CFG_PATTERN_HIGH, hi);
    cfg_index <= wbps_pkg::CFG_PATTERN_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    apply_cfg(wbps_pkg::CFG_PATTERN_LENGTH, len_word);
    cfg_we <= 1'b0;
  endtask

  task automatic write_spare(wbps_pkg::cfg_data_t value);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= value;
    @(posedge clk);
    apply_cfg(CFG_SPARE, value);
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall at random, honor a hold-off request, check every transfer
  initial begin
    int gap;
    scan_report_t want;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report found=%b addr=%h",
                                  out_if.found, out_if.match_address));
      end else begin
        want = expected_reports.pop_front();
        if (out_if.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", out_if.found, want.found));
        if (out_if.match_address !== want.match_address)
          report_mismatch($sformatf("match_address %h, expected %h",
                                    out_if.match_address, want.match_address));
      end
    end
  end

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Pattern "AB?D": idle bytes, plain match, wrap at the top of the address
  // space with the match on the last byte, and a page restart that splits a match
  task automatic test_directed_scans();
    settle_block();
    load_pattern(64'h0000_0000_443F_4241, '1, 64'd4);
    // Bytes before any scan start shift in but report nothing
    send_byte(8'h41, 48'h10, 1'b0, 1'b0, 1'b0);
    send_byte(8'h42, 48'h11, 1'b0, 1'b0, 1'b0);
    // Match inside a scan, then silence until the next scan, even on scan_last
    send_byte(8'h41, 48'h1000, 1'b1, 1'b1, 1'b0);
    send_byte(8'h42, 48'h1001, 1'b0, 1'b0, 1'b0);
    send_byte(8'h99, 48'h1002, 1'b0, 1'b0, 1'b0);
    send_byte(8'h44, 48'h1003, 1'b0, 1'b0, 1'b0);
    send_byte(8'h41, 48'h1004, 1'b0, 1'b0, 1'b0);
    send_byte(8'h42, 48'h1005, 1'b0, 1'b0, 1'b1);
    // Start address wraps below zero; match lands on the final byte
    send_byte(8'h41, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0);
    send_byte(8'h42, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 48'h0, 1'b0, 1'b0, 1'b0);
    send_byte(8'h44, 48'h1, 1'b0, 1'b0, 1'b1);
    // New page mid-scan: the window restarts, so no match across the boundary
    send_byte(8'h41, 48'h2FFE, 1'b1, 1'b1, 1'b0);
    send_byte(8'h42, 48'h2FFF, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 48'h3000, 1'b1, 1'b0, 1'b0);
    send_byte(8'h44, 48'h3001, 1'b0, 1'b0, 1'b0);
    send_byte(8'h00, 48'h3002, 1'b0, 1'b0, 1'b1);
  endtask

  // Length zero acts as one, and the spare register index is ignored
  task automatic test_length_limits();
    settle_block();
    load_pattern(64'h0000_0000_0000_00FF, '0, 64'd0);
    @(posedge clk);
    write_spare('1);
    send_byte(8'hFF, '1, 1'b1, 1'b1, 1'b1);
    send_byte(8'h00, '0, 1'b1, 1'b1, 1'b1);
  endtask

  // One well-formed scan: pages of random size, bytes partly planted from the pattern
  task automatic send_scan(output int sent);
    int n;
    int nbytes;
    int plant;
    logic pf;
    wbps_pkg::byte_t d;
    wbps_pkg::addr_t a;
    n = used_len();
    nbytes = $urandom_range(1, 2 * n + 10);
    if ($urandom_range(0, 7) == 0)
      a = wbps_pkg::addr_t'('1) - wbps_pkg::addr_t'($urandom_range(0, 20));
    else a = wbps_pkg::addr_t'({$urandom, $urandom});
    plant = -1;
    for (int k = 0; k < nbytes; k++) begin
      pf = (k > 0) && ($urandom_range(0, 11) == 0);
      if (plant < 0 && $urandom_range(0, 3) == 0) plant = 0;
      if (plant >= 0) begin
        d = pattern_at(plant);
        if (d == wbps_pkg::WILDCARD_BYTE) d = wbps_pkg::byte_t'($urandom);
        plant++;
        if (plant == n) plant = -1;
      end else if ($urandom_range(0, 1) == 0) begin
        d = pattern_at($urandom_range(0, n - 1));
      end else begin
        d = wbps_pkg::byte_t'($urandom);
      end
      send_byte(d, a, pf, k == 0, k == nbytes - 1);
      a++;
    end
    sent = nbytes;
  endtask

  // Pattern bytes for a phase: extremes for some phases, mixed wildcards otherwise
  function automatic logic [63:0] random_pattern_word(int phase);
    logic [63:0] w;
    if (phase == 1) return '1;
    if (phase == 3) return '0;
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = ($urandom_range(0, 3) == 0) ? wbps_pkg::WILDCARD_BYTE
                                                 : wbps_pkg::byte_t'($urandom);
    return w;
  endfunction

  task automatic test_random_scans();
    int len_val;
    int sent;
    int n;
    wbps_pkg::cfg_data_t len_word;
    for (int phase = 0; phase < 10; phase++) begin
      settle_block();
      case (phase)
        0: len_val = 1;
        1: len_val = 16;
        2: len_val = 0;
        3: len_val = 31;
        4: len_val = 17;
        default: len_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 16);
      endcase
      // Upper bits of the length word are don't-care; drive them at random
      len_word = {$urandom, $urandom};
      len_word[4:0] = len_val[4:0];
      load_pattern(random_pattern_word(phase), random_pattern_word(phase), len_word);
      case (phase % 4)
        0: begin send_gap_max = 19; recv_gap_max = 19; end
        1: begin send_gap_max = 0;  recv_gap_max = 0;  end
        2: begin send_gap_max = 0;  recv_gap_max = 19; end
        default: begin send_gap_max = 19; recv_gap_max = 0; end
      endcase
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: random flags, including broken and unterminated scans
          send_byte(wbps_pkg::byte_t'($urandom), wbps_pkg::addr_t'({$urandom, $urandom}),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          send_scan(n);
          sent += n;
        end
      end
    end
  endtask

  // Hold the receiver off while every byte produces a report, so the input stalls
  task automatic test_output_backpressure();
    settle_block();
    load_pattern({56'h0, wbps_pkg::WILDCARD_BYTE}, '0, 64'd1);
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_off_len = 200;
    for (int k = 0; k < 40; k++)
      send_byte(wbps_pkg::byte_t'($urandom), wbps_pkg::addr_t'({$urandom, $urandom}),
                1'b1, 1'b1, 1'b0);
  endtask

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin
    error_count  = 0;
    hold_off_len = 0;
    send_gap_max = 19;
    recv_gap_max = 19;
    reset_scan_model();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= wbps_pkg::CFG_PATTERN_LOW;
    cfg_data           <= '0;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    in_if.byte_address <= '0;
    in_if.page_first   <= 1'b0;
    in_if.scan_first   <= 1'b0;
    in_if.scan_last    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_scans();
    test_length_limits();
    test_random_scans();
    test_output_backpressure();

    // Drain, then give the block time to show any stray report
    settle_block();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
